[src/assert_macros.svh]
// assertion macros used by the rtl file ghash_accumulator
// no dependencies; each macro expects aclk and aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition that must hold on every rising edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

`endif

[src/ghash_pkg.sv]
// payload types, mode codes and the gf(2^128) multiply for the ghash accumulator
// no dependencies
package ghash_pkg;

    localparam int BlockW  = 128;
    localparam int HalfW   = 64;
    localparam int NBytesW = 5;
    localparam int CountW  = 61;
    localparam int BlockBytes = BlockW / 8;

    typedef enum logic [1:0] {
        MODE_AAD      = 2'd0,
        MODE_TEXT     = 2'd1,
        MODE_FINALIZE = 2'd2,
        MODE_NOP      = 2'd3
    } ga_mode_t;

    typedef enum logic [0:0] {
        REG_KEY_HI = 1'b0,
        REG_KEY_LO = 1'b1
    } ga_reg_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [HalfW-1:0]   data_hi;
        logic [HalfW-1:0]   data_lo;
        logic [NBytesW-1:0] valid_bytes;
    } ga_in_t;

    typedef struct packed {
        logic [HalfW-1:0] digest_hi;
        logic [HalfW-1:0] digest_lo;
    } ga_out_t;

    // gcm bit order: coefficient of x^0 is bit 127 of the word
    function automatic logic [BlockW-1:0] gcm_field_mul(input logic [BlockW-1:0] a,
                                                        input logic [BlockW-1:0] b);
        logic [BlockW-1:0]   ar;
        logic [BlockW-1:0]   br;
        logic [2*BlockW-2:0] prod;
        logic [BlockW-2:0]   top1;
        logic [BlockW+5:0]   fold1;
        logic [BlockW+5:0]   top1_ext;
        logic [5:0]          top2;
        logic [BlockW-1:0]   top2_ext;
        logic [BlockW-1:0]   red;
        logic [BlockW-1:0]   res;
        for (int i = 0; i < BlockW; i++) begin
            ar[i] = a[BlockW-1-i];
            br[i] = b[BlockW-1-i];
        end
        // carryless product as an xor of independent partial products
        prod = '0;
        for (int i = 0; i < BlockW; i++) begin
            if (ar[i]) begin
                prod = prod ^ ({{(BlockW-1){1'b0}}, br} << i);
            end
        end
        // reduce by x^128 + x^7 + x^2 + x + 1 in two folds
        top1     = prod[2*BlockW-2:BlockW];
        top1_ext = {7'b0, top1};
        fold1    = {6'b0, prod[BlockW-1:0]} ^ top1_ext ^ (top1_ext << 1)
                 ^ (top1_ext << 2) ^ (top1_ext << 7);
        top2     = fold1[BlockW+5:BlockW];
        top2_ext = {{(BlockW-6){1'b0}}, top2};
        red      = fold1[BlockW-1:0] ^ top2_ext ^ (top2_ext << 1)
                 ^ (top2_ext << 2) ^ (top2_ext << 7);
        for (int i = 0; i < BlockW; i++) begin
            res[BlockW-1-i] = red[i];
        end
        return res;
    endfunction

endpackage

[src/ghash_accumulator.sv]
// channel   handshake          payload
// s_        s_valid/s_ready    s_data  (ghash_pkg::ga_in_t)
// m_        m_valid/m_ready    m_data  (ghash_pkg::ga_out_t)
// cfg_      cfg_we             cfg_index, cfg_wdata
// one block per clock unless stalled: input register, then gf(2^128) multiply into the
// accumulator; the full 128x128 carryless multiply and reduction set the cycle time
// a finalize waits in the input register; when it advances, its digest is registered
// s_ready drops only while a finalize waits behind a digest that is not yet taken
// synchronous active-low reset clears the accumulator, counters, key and valids
// depends on ghash_pkg and assert_macros.svh
`include "assert_macros.svh"

module ghash_accumulator (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [ghash_pkg::HalfW-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  ghash_pkg::ga_in_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output ghash_pkg::ga_out_t         m_data
);
    import ghash_pkg::*;

    logic [HalfW-1:0]   key_hi_reg;
    logic [HalfW-1:0]   key_lo_reg;

    // input register
    logic               in_valid_reg;
    logic               in_final_reg;
    logic               in_text_reg;
    logic [BlockW-1:0]  in_block_reg;
    logic [NBytesW-1:0] in_nbytes_reg;

    logic [BlockW-1:0]  acc_reg;
    logic [CountW-1:0]  aad_count_reg;
    logic [CountW-1:0]  text_count_reg;

    logic               out_valid_reg;
    ga_out_t            out_data_reg;

    logic               stall;
    logic               advance;
    logic [NBytesW-1:0] nbytes_sat;
    logic [BlockW-1:0]  raw_block;
    logic [BlockW-1:0]  masked_block;
    logic [BlockW-1:0]  mul_operand;
    logic [BlockW-1:0]  acc_next;
    logic [BlockW-1:0]  key;

    assign stall     = in_valid_reg && in_final_reg && out_valid_reg && !m_ready;
    assign advance   = in_valid_reg && !stall;
    assign s_ready   = !stall;
    assign key       = {key_hi_reg, key_lo_reg};
    assign raw_block = {s_data.data_hi, s_data.data_lo};

    // saturate the byte count and zero the bytes past it
    always_comb begin
        nbytes_sat = (s_data.valid_bytes > NBytesW'(BlockBytes)) ?
                     NBytesW'(BlockBytes) : s_data.valid_bytes;
        for (int b = 0; b < BlockBytes; b++) begin
            masked_block[BlockW-1-8*b -: 8] = (NBytesW'(b) < nbytes_sat) ?
                raw_block[BlockW-1-8*b -: 8] : 8'h00;
        end
    end

    // finalize absorbs the lengths block: bit counts of both kinds
    always_comb begin
        if (in_final_reg) begin
            mul_operand = acc_reg ^ {aad_count_reg, 3'b000, text_count_reg, 3'b000};
        end else begin
            mul_operand = acc_reg ^ in_block_reg;
        end
        acc_next = gcm_field_mul(mul_operand, key);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_hi_reg     <= '0;
            key_lo_reg     <= '0;
            in_valid_reg   <= 1'b0;
            acc_reg        <= '0;
            aad_count_reg  <= '0;
            text_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_KEY_HI: key_hi_reg <= cfg_wdata;
                    REG_KEY_LO: key_lo_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (s_ready) begin
                in_valid_reg <= s_valid && (s_data.mode != MODE_NOP);
            end

            // a new digest may replace the one taken at this edge
            if (advance && in_final_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (advance) begin
                if (in_final_reg) begin
                    acc_reg        <= '0;
                    aad_count_reg  <= '0;
                    text_count_reg <= '0;
                end else begin
                    acc_reg <= acc_next;
                    if (in_text_reg) begin
                        text_count_reg <= text_count_reg + CountW'(in_nbytes_reg);
                    end else begin
                        aad_count_reg <= aad_count_reg + CountW'(in_nbytes_reg);
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_final_reg  <= (s_data.mode == MODE_FINALIZE);
            in_text_reg   <= (s_data.mode == MODE_TEXT);
            in_block_reg  <= masked_block;
            in_nbytes_reg <= nbytes_sat;
        end
        if (advance && in_final_reg) begin
            out_data_reg.digest_hi <= acc_next[BlockW-1:HalfW];
            out_data_reg.digest_lo <= acc_next[HalfW-1:0];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `ASSERT_CLK(a_final_clears, (advance && in_final_reg) |=> (acc_reg == '0 && aad_count_reg == '0 && text_count_reg == '0), "state not cleared after finalize")
    `ASSERT_ALWAYS(a_ready_low_only_on_stall, s_ready || (m_valid && !m_ready && in_valid_reg && in_final_reg), "input stalled without a waiting digest")
    `ASSERT_CLK(a_digest_from_final, $rose(out_valid_reg) |-> $past(advance && in_final_reg), "digest raised without a finalize request")

endmodule

[dv/ghash_checker.sv]
// digest predictor and scoreboard for the ghash accumulator
// watches the config port and both channels; depends on ghash_pkg
`timescale 1ns / 1ps

module ghash_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [ghash_pkg::HalfW-1:0] cfg_wdata,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  ghash_pkg::ga_in_t           s_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  ghash_pkg::ga_out_t          m_data,
    output int unsigned                 fail_count,
    output int unsigned                 outstanding
);
    import ghash_pkg::*;

    logic [127:0] hash_key;
    logic [127:0] ghash_acc;
    logic [60:0]  aad_bytes;
    logic [60:0]  text_bytes;
    logic [127:0] expected_digests[$];
    int unsigned  mismatches;

    // shift-and-add multiply, bit 127 of the word is the x^0 coefficient
    function automatic logic [127:0] mul_by_key(input logic [127:0] x,
                                                input logic [127:0] h);
        logic [127:0] z;
        logic [127:0] v;
        z = '0;
        v = h;
        for (int i = 0; i < 128; i++) begin
            if (x[127-i]) begin
                z = z ^ v;
            end
            if (v[0]) begin
                v = (v >> 1) ^ {8'he1, 120'b0};
            end else begin
                v = v >> 1;
            end
        end
        return z;
    endfunction

    function automatic logic [127:0] byte_keep_mask(input logic [4:0] nbytes);
        int unsigned n;
        n = (nbytes > 16) ? 16 : nbytes;
        if (n == 0) begin
            return '0;
        end
        return {128{1'b1}} << (8 * (16 - n));
    endfunction

    task automatic absorb_request(input ga_in_t req);
        logic [127:0] lengths;
        int unsigned  n;
        case (ga_mode_t'(req.mode))
            MODE_FINALIZE: begin
                lengths   = {aad_bytes, 3'b000, text_bytes, 3'b000};
                ghash_acc = mul_by_key(ghash_acc ^ lengths, hash_key);
                expected_digests.push_back(ghash_acc);
                ghash_acc  = '0;
                aad_bytes  = '0;
                text_bytes = '0;
            end
            MODE_NOP: begin
            end
            default: begin
                n = (req.valid_bytes > 16) ? 16 : req.valid_bytes;
                ghash_acc = mul_by_key(ghash_acc ^ ({req.data_hi, req.data_lo}
                                       & byte_keep_mask(req.valid_bytes)), hash_key);
                if (ga_mode_t'(req.mode) == MODE_AAD) begin
                    aad_bytes = aad_bytes + 61'(n);
                end else begin
                    text_bytes = text_bytes + 61'(n);
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        logic [127:0] want;
        if (!aresetn) begin
            hash_key   = '0;
            ghash_acc  = '0;
            aad_bytes  = '0;
            text_bytes = '0;
            mismatches = 0;
            expected_digests.delete();
        end else begin
            if (cfg_we) begin
                case (ga_reg_t'(cfg_index))
                    REG_KEY_HI: hash_key[127:64] = cfg_wdata;
                    REG_KEY_LO: hash_key[63:0]   = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                absorb_request(s_data);
            end
            if (m_valid && m_ready) begin
                if (expected_digests.size() == 0) begin
                    $error("digest with no finalize request pending: %h %h",
                           m_data.digest_hi, m_data.digest_lo);
                    mismatches++;
                end else begin
                    want = expected_digests.pop_front();
                    if (m_data.digest_hi !== want[127:64]) begin
                        $error("digest_hi expected %h actual %h", want[127:64],
                               m_data.digest_hi);
                        mismatches++;
                    end
                    if (m_data.digest_lo !== want[63:0]) begin
                        $error("digest_lo expected %h actual %h", want[63:0],
                               m_data.digest_lo);
                        mismatches++;
                    end
                end
            end
        end
        fail_count  <= mismatches;
        outstanding <= expected_digests.size();
    end

endmodule

[dv/testbench.sv]
// top of the ghash accumulator testbench: clock, reset, key writes and request stimulus
// depends on ghash_pkg, ghash_accumulator and ghash_checker
`timescale 1ns / 1ps

module testbench;
    import ghash_pkg::*;

    localparam int unsigned LongStall    = 300;
    localparam int unsigned DrainCycles  = 4;
    localparam int unsigned PhaseItems   = 250;
    localparam int unsigned KeyPhases    = 8;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [0:0]   cfg_index = REG_KEY_HI;
    logic [63:0]  cfg_wdata = '0;
    logic         s_valid   = 1'b0;
    logic         s_ready;
    ga_in_t       s_data    = '0;
    logic         m_valid;
    logic         m_ready   = 1'b0;
    ga_out_t      m_data;

    int unsigned  fail_count;
    int unsigned  outstanding;

    // quiet: no idling on either side; pressure_on: one long receiver hold-off
    bit           quiet       = 1'b0;
    bit           pressure_on = 1'b0;
    bit           stall_done  = 1'b0;
    int unsigned  stall_cycles = 0;
    int unsigned  sent;

    ghash_accumulator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    ghash_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5 aclk = ~aclk;

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        if (pressure_on && !stall_done) begin
            m_ready <= 1'b0;
            stall_cycles = stall_cycles + 1;
            if (stall_cycles == LongStall) begin
                stall_done = 1'b1;
            end
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 12);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic ga_in_t block_req(input ga_mode_t mode, input int unsigned nbytes);
        ga_in_t req;
        req.mode        = mode;
        req.data_hi     = rand64();
        req.data_lo     = rand64();
        req.valid_bytes = 5'(nbytes);
        return req;
    endfunction

    task automatic push_request(input ga_in_t req);
        while (!quiet && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (ga_mode_t'(req.mode) != MODE_NOP) begin
            sent++;
        end
    endtask

    // idle the request side and wait until every digest is taken
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_key(input logic [63:0] key_hi, input logic [63:0] key_lo);
        cfg_we    <= 1'b1;
        cfg_index <= REG_KEY_HI;
        cfg_wdata <= key_hi;
        @(posedge aclk);
        cfg_index <= REG_KEY_LO;
        cfg_wdata <= key_lo;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // aad blocks then text blocks (an occasional block swaps kind), last of each kind often partial, then finalize
    task automatic send_message();
        int unsigned n_aad;
        int unsigned n_text;
        int unsigned nbytes;
        ga_mode_t    mode;
        n_aad  = $urandom_range(0, 3);
        n_text = $urandom_range(0, 6);
        for (int unsigned k = 0; k < n_aad + n_text; k++) begin
            mode = (k < n_aad) ? MODE_AAD : MODE_TEXT;
            if ($urandom_range(9) == 0) begin
                mode = (mode == MODE_AAD) ? MODE_TEXT : MODE_AAD;
            end
            nbytes = 16;
            if ((k + 1 == n_aad || k + 1 == n_aad + n_text) && $urandom_range(2) == 0) begin
                nbytes = $urandom_range(1, 16);
            end
            push_request(block_req(mode, nbytes));
        end
        push_request(block_req(MODE_FINALIZE, $urandom_range(0, 31)));
    endtask

    task automatic send_noise();
        ga_in_t req;
        req.mode        = 2'($urandom_range(0, 3));
        req.data_hi     = rand64();
        req.data_lo     = rand64();
        req.valid_bytes = 5'($urandom_range(0, 31));
        push_request(req);
    endtask

    initial begin
        int unsigned sizes[8] = '{1, 7, 8, 9, 15, 16, 17, 31};
        ga_in_t      req;
        int unsigned target;

        sent = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_key(rand64(), rand64());

        // finalize with nothing absorbed gives a zero digest
        push_request(block_req(MODE_FINALIZE, 0));
        req = block_req(MODE_AAD, 16);
        req.data_hi = '1;
        req.data_lo = '1;
        push_request(req);
        req.data_hi = '0;
        req.data_lo = '0;
        push_request(req);
        // zero valid bytes: absorbed as an all-zero block
        req = block_req(MODE_TEXT, 0);
        req.data_hi = '1;
        req.data_lo = '1;
        push_request(req);
        foreach (sizes[i]) begin
            req.valid_bytes = 5'(sizes[i]);
            push_request(req);
        end
        push_request(block_req(MODE_NOP, 16));
        req = block_req(MODE_FINALIZE, 31);
        req.data_hi = '1;
        req.data_lo = '1;
        push_request(req);
        // text ahead of aad, then a nop inside the message
        push_request(block_req(MODE_TEXT, 16));
        push_request(block_req(MODE_AAD, 5));
        push_request(block_req(MODE_NOP, 3));
        push_request(block_req(MODE_FINALIZE, 16));
        drain();

        for (int unsigned phase = 0; phase < KeyPhases; phase++) begin
            case (phase)
                0: write_key('0, '0);
                1: write_key('1, '1);
                2: write_key(64'h8000_0000_0000_0000, '0);
                3: write_key('0, 64'h1);
                default: write_key(rand64(), rand64());
            endcase
            quiet <= (phase == 5);
            @(posedge aclk);
            if (phase == 6) begin
                // receiver holds off while finalize requests keep coming
                pressure_on <= 1'b1;
                quiet       <= 1'b1;
                for (int unsigned k = 0; k < 40; k++) begin
                    push_request(block_req((k % 2 == 0) ? MODE_TEXT : MODE_FINALIZE,
                                           $urandom_range(0, 16)));
                end
                quiet <= 1'b0;
            end
            target = sent + PhaseItems;
            while (sent < target) begin
                if ($urandom_range(99) < 80) begin
                    send_message();
                end else begin
                    send_noise();
                end
            end
            drain();
        end

        if (fail_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/ghash_pkg.sv
src/ghash_accumulator.sv
dv/ghash_checker.sv
dv/testbench.sv
